// ===== design/arp_pkg.sv =====
// Shared types, codes and constants of the ARP cache engine.
package arp_pkg;

  // Item actions
  localparam logic [2:0] ACT_PKT  = 3'd0;
  localparam logic [2:0] ACT_RES  = 3'd1;
  localparam logic [2:0] ACT_TICK = 3'd2;
  localparam logic [2:0] ACT_UP   = 3'd3;
  localparam logic [2:0] ACT_DOWN = 3'd4;
  localparam logic [2:0] ACT_RM   = 3'd5;

  // Result kinds
  localparam logic [2:0] KIND_DONE     = 3'd0;
  localparam logic [2:0] KIND_REQ      = 3'd1;
  localparam logic [2:0] KIND_REPLY    = 3'd2;
  localparam logic [2:0] KIND_RESOLVED = 3'd3;
  localparam logic [2:0] KIND_NOTRES   = 3'd4;
  localparam logic [2:0] KIND_HIT      = 3'd5;
  localparam logic [2:0] KIND_MISS     = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_OWN_MAC = 2'd0;
  localparam logic [1:0] REG_OWN_IP  = 2'd1;
  localparam logic [1:0] REG_RES_TO  = 2'd2;
  localparam logic [1:0] REG_INC_TO  = 2'd3;

  // Packet field values
  localparam logic [10:0] ARP_MIN_LEN = 11'd8;  // htype + ptype + hlen + plen + op
  localparam logic [15:0] ETH_P_IP    = 16'h0800;
  localparam logic [7:0]  ARP_HW_LEN  = 8'd6;
  localparam logic [7:0]  ARP_PR_LEN  = 8'd4;
  localparam logic [15:0] OP_REQ      = 16'd1;
  localparam logic [15:0] OP_REP      = 16'd2;
  localparam logic [47:0] BCAST_MAC   = 48'hffff_ffff_ffff;
  localparam logic [47:0] ZERO_MAC    = 48'h0;

  localparam logic [15:0] RES_TO_RESET = 16'd300;
  localparam logic [15:0] INC_TO_RESET = 16'd3;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] expiry;
  } entry_t;

  typedef enum logic [1:0] {KEY_SIP, KEY_Q, KEY_INS} key_sel_t;
  typedef enum logic [2:0] {IDX_HOLD, IDX_CLR, IDX_INC, IDX_DEC, IDX_COUNT, IDX_FIDX} idx_op_t;
  typedef enum logic [1:0] {RD_IDX, RD_IDX1, RD_IDXM1, RD_ZERO} rd_sel_t;
  typedef enum logic [1:0] {WR_MOVE, WR_INS, WR_UPD} wr_sel_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic {INS_LEARNED, INS_INCOMPLETE} ins_src_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       key_load;
    key_sel_t   key_sel;
    logic       ins_load;
    ins_src_t   ins_src;
    idx_op_t    idx_op;
    logic       pos_load;
    logic       found_clr;
    logic       found_set;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wr_sel_t    wr_sel;
    cnt_op_t    cnt_op;
    logic       drop_cap;
    logic       hit_cap;
    logic       emit;
    logic [2:0] emit_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] act;
    logic       pkt_ok;
    logic       op_req;
    logic       op_rep;
    logic       tip_own;
    logic       announce;
    logic       tmac_own;
    logic       own_ip_nz;
    logic       idx_lt_cnt;
    logic       idx1_lt_cnt;
    logic       idx_gt_pos;
    logic       cnt_nz;
    logic       full;
    logic       found;
    logic       key_hit;
    logic       rd_exp_zero;
    logic       rd_exp_le_now;
    logic       rd_exp_gt_new;
    logic       ins_timed;
    logic       drop_unres;
    logic       out_free;
  } sts_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_REQ_INS1, S_REQ_ANN, S_INS, S_FIND_RD, S_FIND_CHK,
    S_INS_CHK, S_INS_FRD, S_INS_FCHK, S_DROP_CAP, S_DROP_RD, S_DROP_WR,
    S_DROP_END, S_INS_POS, S_POS_RD, S_POS_CHK, S_SH_INIT, S_SH_CHK, S_SH_WR,
    S_REP_UPD, S_RES_CHK, S_RES_MISS, S_RES_MISS2, S_TICK_RD, S_TICK_CHK,
    S_RM_CHK, S_EMIT, S_DONE
  } st_t;

endpackage

// ===== design/arp_datapath.sv =====
// Datapath of the ARP cache: entry memory, item and config registers, result register.
module arp_datapath import arp_pkg::*; #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [47:0]  cfg_wdata,
  input  logic [287:0] s_tdata,
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CW-1:0] NUM_ENTRIES = CW'(CACHE_ENTRIES);

  // Item fields
  logic [2:0]  action;
  logic [31:0] now_seconds;
  logic [10:0] pkt_length;
  logic [15:0] pkt_protocol;
  logic [7:0]  pkt_hw_len;
  logic [7:0]  pkt_proto_len;
  logic [15:0] pkt_op;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [47:0] target_mac;
  logic [31:0] target_ip;
  logic [31:0] query_ip;

  // Configuration
  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [15:0] resolved_timeout;
  logic [15:0] incomplete_timeout;

  // Working registers
  entry_t      mem [CACHE_ENTRIES];
  entry_t      rd_q;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] fidx;
  logic        found;
  logic [31:0] key;
  logic [31:0] ins_ip;
  logic [47:0] ins_mac;
  logic [31:0] ins_exp;
  logic        ins_timed;
  logic [31:0] drop_ip;
  logic        drop_unres;
  logic [47:0] hit_mac;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [47:0] out_mac;
  logic [31:0] out_ip;
  logic        out_last;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [15:0]   ins_to;
  logic [32:0]   exp_sum;
  logic [31:0]   exp_new;
  logic [CW:0]   idx_p1;
  logic [CW-1:0] idx_m1;
  logic [47:0]   emit_mac;
  logic [31:0]   emit_ip;

  assign idx_p1 = {1'b0, idx} + 1'b1;
  assign idx_m1 = idx - 1'b1;

  // Expiry of a new entry, saturated at all ones; zero timeout means static
  assign ins_to  = (cmd.ins_src == INS_INCOMPLETE) ? incomplete_timeout : resolved_timeout;
  assign exp_sum = {1'b0, now_seconds} + {17'b0, ins_to};
  assign exp_new = exp_sum[32] ? 32'hffff_ffff : exp_sum[31:0];

  // Memory address and data selection
  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:   rd_addr = idx[AW-1:0];
      RD_IDX1:  rd_addr = idx_p1[AW-1:0];
      RD_IDXM1: rd_addr = idx_m1[AW-1:0];
      default:  rd_addr = '0;
    endcase
    case (cmd.wr_sel)
      WR_MOVE: begin
        wr_addr = idx[AW-1:0];
        wr_data = rd_q;
      end
      WR_UPD: begin
        // In-place update always takes now + timeout, even for a zero timeout
        wr_addr = fidx[AW-1:0];
        wr_data = '{ip: ins_ip, mac: ins_mac, expiry: exp_new};
      end
      default: begin
        wr_addr = idx[AW-1:0];
        wr_data = '{ip: ins_ip, mac: ins_mac, expiry: ins_exp};
      end
    endcase
  end

  // Entry memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Result value for the kind being emitted
  always_comb begin
    case (cmd.emit_kind)
      KIND_REQ: begin
        emit_mac = BCAST_MAC;
        emit_ip  = (action == ACT_UP) ? own_ip : query_ip;
      end
      KIND_REPLY, KIND_RESOLVED: begin
        emit_mac = sender_mac;
        emit_ip  = sender_ip;
      end
      KIND_NOTRES: begin
        emit_mac = ZERO_MAC;
        emit_ip  = drop_ip;
      end
      KIND_HIT: begin
        emit_mac = hit_mac;
        emit_ip  = query_ip;
      end
      KIND_MISS: begin
        emit_mac = ZERO_MAC;
        emit_ip  = query_ip;
      end
      default: begin
        emit_mac = ZERO_MAC;
        emit_ip  = 32'h0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count              <= '0;
      idx                <= '0;
      found              <= 1'b0;
      out_valid          <= 1'b0;
      own_mac            <= 48'h0;
      own_ip             <= 32'h0;
      resolved_timeout   <= RES_TO_RESET;
      incomplete_timeout <= INC_TO_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_OWN_MAC: own_mac <= cfg_wdata;
          REG_OWN_IP:  own_ip <= cfg_wdata[31:0];
          REG_RES_TO:  resolved_timeout <= cfg_wdata[15:0];
          REG_INC_TO:  incomplete_timeout <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      case (cmd.cnt_op)
        CNT_INC: count <= count + 1'b1;
        CNT_DEC: count <= count - 1'b1;
        default: ;
      endcase
      case (cmd.idx_op)
        IDX_CLR:   idx <= '0;
        IDX_INC:   idx <= idx + 1'b1;
        IDX_DEC:   idx <= idx_m1;
        IDX_COUNT: idx <= count;
        IDX_FIDX:  idx <= fidx;
        default: ;
      endcase
      if (cmd.found_clr) begin
        found <= 1'b0;
      end else if (cmd.found_set) begin
        found <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action        <= s_tuser;
      now_seconds   <= s_tdata[31:0];
      pkt_length    <= s_tdata[42:32];
      pkt_protocol  <= s_tdata[58:43];
      pkt_hw_len    <= s_tdata[66:59];
      pkt_proto_len <= s_tdata[74:67];
      pkt_op        <= s_tdata[90:75];
      sender_mac    <= s_tdata[138:91];
      sender_ip     <= s_tdata[170:139];
      target_mac    <= s_tdata[218:171];
      target_ip     <= s_tdata[250:219];
      query_ip      <= s_tdata[282:251];
    end
    if (cmd.key_load) begin
      case (cmd.key_sel)
        KEY_SIP: key <= sender_ip;
        KEY_Q:   key <= query_ip;
        default: key <= ins_ip;
      endcase
    end
    if (cmd.ins_load) begin
      ins_ip    <= (cmd.ins_src == INS_INCOMPLETE) ? query_ip : sender_ip;
      ins_mac   <= (cmd.ins_src == INS_INCOMPLETE) ? ZERO_MAC : sender_mac;
      ins_timed <= (ins_to != 16'h0);
      ins_exp   <= (ins_to != 16'h0) ? exp_new : 32'h0;
    end
    if (cmd.found_set) begin
      fidx <= idx;
    end
    if (cmd.pos_load) begin
      pos <= idx;
    end
    if (cmd.drop_cap) begin
      drop_ip    <= rd_q.ip;
      drop_unres <= (rd_q.mac == ZERO_MAC);
    end
    if (cmd.hit_cap) begin
      hit_mac <= rd_q.mac;
    end
    if (cmd.emit) begin
      out_kind <= cmd.emit_kind;
      out_mac  <= emit_mac;
      out_ip   <= emit_ip;
      out_last <= (cmd.emit_kind == KIND_DONE);
    end
  end

  // Status toward the controller
  always_comb begin
    sts.act           = action;
    sts.pkt_ok        = (pkt_length >= ARP_MIN_LEN) && (pkt_protocol == ETH_P_IP) &&
                        (pkt_hw_len == ARP_HW_LEN) && (pkt_proto_len == ARP_PR_LEN);
    sts.op_req        = (pkt_op == OP_REQ);
    sts.op_rep        = (pkt_op == OP_REP);
    sts.tip_own       = (target_ip == own_ip);
    sts.announce      = (target_ip == sender_ip) && (target_mac == ZERO_MAC);
    sts.tmac_own      = (target_mac == own_mac);
    sts.own_ip_nz     = (own_ip != 32'h0);
    sts.idx_lt_cnt    = (idx < count);
    sts.idx1_lt_cnt   = (idx_p1 < {1'b0, count});
    sts.idx_gt_pos    = (idx > pos);
    sts.cnt_nz        = (count != '0);
    sts.full          = (count >= NUM_ENTRIES);
    sts.found         = found;
    sts.key_hit       = (rd_q.ip == key);
    sts.rd_exp_zero   = (rd_q.expiry == 32'h0);
    sts.rd_exp_le_now = (rd_q.expiry <= now_seconds);
    sts.rd_exp_gt_new = (rd_q.expiry > ins_exp) || (rd_q.expiry == 32'h0);
    sts.ins_timed     = ins_timed;
    sts.drop_unres    = drop_unres;
    sts.out_free      = !out_valid || m_tready;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_ip, out_mac};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // Fill count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= NUM_ENTRIES)
    else $error("entry count beyond table size");

  // Writes land inside the filled area or the slot just past it
  a_wr_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> ({{(CW+1-AW){1'b0}}, wr_addr} <= {1'b0, count}))
    else $error("entry write outside filled area");

  // Only the closing result carries tlast
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == KIND_DONE))
    else $error("tlast on a result other than done");

endmodule

// ===== design/arp_controller.sv =====
// Sequencer of the ARP cache: walks searches, inserts and drops one entry at a time.
module arp_controller import arp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  st_t        state, state_next;
  st_t        emit_ret, emit_ret_next;
  st_t        find_ret, find_ret_next;
  st_t        drop_ret, drop_ret_next;
  st_t        ins_ret, ins_ret_next;
  logic [2:0] emit_kind, emit_kind_next;

  // State and return registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_ret  <= S_IDLE;
      find_ret  <= S_IDLE;
      drop_ret  <= S_IDLE;
      ins_ret   <= S_IDLE;
      emit_kind <= KIND_DONE;
    end else begin
      state     <= state_next;
      emit_ret  <= emit_ret_next;
      find_ret  <= find_ret_next;
      drop_ret  <= drop_ret_next;
      ins_ret   <= ins_ret_next;
      emit_kind <= emit_kind_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    emit_ret_next  = emit_ret;
    find_ret_next  = find_ret;
    drop_ret_next  = drop_ret;
    ins_ret_next   = ins_ret;
    emit_kind_next = emit_kind;
    cmd            = '0;
    cmd.emit_kind  = emit_kind;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISP;
        end
      end

      S_DISP: begin
        case (sts.act)
          ACT_PKT: begin
            if (!sts.pkt_ok) begin
              state_next = S_DONE;
            end else if (sts.op_req) begin
              if (sts.tip_own) begin
                emit_kind_next = KIND_REPLY;
                emit_ret_next  = S_REQ_INS1;
                state_next     = S_EMIT;
              end else begin
                state_next = S_REQ_ANN;
              end
            end else if (sts.op_rep && sts.tmac_own) begin
              cmd.key_load  = 1'b1;
              cmd.key_sel   = KEY_SIP;
              cmd.ins_load  = 1'b1;
              cmd.ins_src   = INS_LEARNED;
              cmd.idx_op    = IDX_CLR;
              cmd.found_clr = 1'b1;
              find_ret_next = S_REP_UPD;
              state_next    = S_FIND_RD;
            end else begin
              state_next = S_DONE;
            end
          end
          ACT_RES, ACT_RM: begin
            cmd.key_load  = 1'b1;
            cmd.key_sel   = KEY_Q;
            cmd.idx_op    = IDX_CLR;
            cmd.found_clr = 1'b1;
            find_ret_next = (sts.act == ACT_RES) ? S_RES_CHK : S_RM_CHK;
            state_next    = S_FIND_RD;
          end
          ACT_TICK, ACT_DOWN: state_next = S_TICK_RD;
          ACT_UP: begin
            if (sts.own_ip_nz) begin
              emit_kind_next = KIND_REQ;
              emit_ret_next  = S_DONE;
              state_next     = S_EMIT;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end

      // Request for us: cache the sender, then look at the announcement rule
      S_REQ_INS1: begin
        cmd.ins_load = 1'b1;
        cmd.ins_src  = INS_LEARNED;
        ins_ret_next = S_REQ_ANN;
        state_next   = S_INS;
      end

      S_REQ_ANN: begin
        if (sts.announce) begin
          cmd.ins_load = 1'b1;
          cmd.ins_src  = INS_LEARNED;
          ins_ret_next = S_DONE;
          state_next   = S_INS;
        end else begin
          state_next = S_DONE;
        end
      end

      // Insert: search for a duplicate first
      S_INS: begin
        cmd.key_load  = 1'b1;
        cmd.key_sel   = KEY_INS;
        cmd.idx_op    = IDX_CLR;
        cmd.found_clr = 1'b1;
        find_ret_next = S_INS_CHK;
        state_next    = S_FIND_RD;
      end

      // Linear search by IP
      S_FIND_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_FIND_CHK;
        end else begin
          state_next = find_ret;
        end
      end

      S_FIND_CHK: begin
        if (sts.key_hit) begin
          cmd.found_set = 1'b1;
          state_next    = find_ret;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_FIND_RD;
        end
      end

      S_INS_CHK: begin
        if (sts.found) begin
          state_next = ins_ret;
        end else if (sts.full) begin
          state_next = S_INS_FRD;
        end else begin
          state_next = S_INS_POS;
        end
      end

      // Full table: look at the front entry
      S_INS_FRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        cmd.idx_op = IDX_CLR;
        state_next = S_INS_FCHK;
      end

      S_INS_FCHK: begin
        if (sts.rd_exp_zero) begin
          state_next = ins_ret;
        end else begin
          drop_ret_next = S_INS_POS;
          state_next    = S_DROP_CAP;
        end
      end

      // Drop the entry at idx; its data sits in the read register
      S_DROP_CAP: begin
        cmd.drop_cap = 1'b1;
        state_next   = S_DROP_RD;
      end

      S_DROP_RD: begin
        if (sts.idx1_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX1;
          state_next = S_DROP_WR;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_DROP_END;
        end
      end

      S_DROP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MOVE;
        cmd.idx_op = IDX_INC;
        state_next = S_DROP_RD;
      end

      S_DROP_END: begin
        if (sts.drop_unres) begin
          emit_kind_next = KIND_NOTRES;
          emit_ret_next  = drop_ret;
          state_next     = S_EMIT;
        end else begin
          state_next = drop_ret;
        end
      end

      // Find the slot: for a timed entry, the first entry expiring later or static; a static entry goes at the end
      S_INS_POS: begin
        cmd.idx_op = sts.ins_timed ? IDX_CLR : IDX_COUNT;
        state_next = S_POS_RD;
      end

      S_POS_RD: begin
        if (sts.ins_timed && sts.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_POS_CHK;
        end else begin
          cmd.pos_load = 1'b1;
          state_next   = S_SH_INIT;
        end
      end

      S_POS_CHK: begin
        if (sts.rd_exp_gt_new) begin
          cmd.pos_load = 1'b1;
          state_next   = S_SH_INIT;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_POS_RD;
        end
      end

      // Open the slot by moving the tail up one place
      S_SH_INIT: begin
        cmd.idx_op = IDX_COUNT;
        state_next = S_SH_CHK;
      end

      S_SH_CHK: begin
        if (sts.idx_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDXM1;
          state_next = S_SH_WR;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_INS;
          cmd.cnt_op = CNT_INC;
          state_next = ins_ret;
        end
      end

      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MOVE;
        cmd.idx_op = IDX_DEC;
        state_next = S_SH_CHK;
      end

      // Reply for us: update the entry in place if it is cached, always notify
      S_REP_UPD: begin
        if (sts.found) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_UPD;
        end
        emit_kind_next = KIND_RESOLVED;
        emit_ret_next  = S_DONE;
        state_next     = S_EMIT;
      end

      S_RES_CHK: begin
        if (sts.found) begin
          cmd.hit_cap    = 1'b1;
          emit_kind_next = KIND_HIT;
          emit_ret_next  = S_DONE;
          state_next     = S_EMIT;
        end else begin
          cmd.ins_load = 1'b1;
          cmd.ins_src  = INS_INCOMPLETE;
          ins_ret_next = S_RES_MISS;
          state_next   = S_INS;
        end
      end

      S_RES_MISS: begin
        emit_kind_next = KIND_REQ;
        emit_ret_next  = S_RES_MISS2;
        state_next     = S_EMIT;
      end

      S_RES_MISS2: begin
        emit_kind_next = KIND_MISS;
        emit_ret_next  = S_DONE;
        state_next     = S_EMIT;
      end

      // Tick drops expired timed front entries; link down drops all timed front entries
      S_TICK_RD: begin
        if (sts.cnt_nz) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ZERO;
          cmd.idx_op = IDX_CLR;
          state_next = S_TICK_CHK;
        end else begin
          state_next = S_DONE;
        end
      end

      S_TICK_CHK: begin
        if (!sts.rd_exp_zero && ((sts.act == ACT_DOWN) || sts.rd_exp_le_now)) begin
          drop_ret_next = S_TICK_RD;
          state_next    = S_DROP_CAP;
        end else begin
          state_next = S_DONE;
        end
      end

      S_RM_CHK: begin
        if (sts.found) begin
          cmd.idx_op    = IDX_FIDX;
          drop_ret_next = S_DONE;
          state_next    = S_DROP_CAP;
        end else begin
          state_next = S_DONE;
        end
      end

      // Hand one result to the output register
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = emit_ret;
        end
      end

      S_DONE: begin
        emit_kind_next = KIND_DONE;
        emit_ret_next  = S_IDLE;
        state_next     = S_EMIT;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // A result is loaded only from the emit state
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == S_EMIT))
    else $error("result loaded outside emit state");

  // Every accepted item starts with dispatch
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> (state == S_DISP))
    else $error("item load did not start dispatch");

  // The closing done result returns the block to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.emit_kind == KIND_DONE)) |=> (state == S_IDLE))
    else $error("done result did not end the item");

endmodule

// ===== design/arp_cache_engine.sv =====
// Top level of the ARP cache engine: controller and datapath.
// ARP cache for IPv4 over Ethernet. One item (a received ARP packet or a
// command in s_tuser) is taken at a time; its notices and frame requests
// leave on the m_ side, closed by a done result with tlast. The table is a
// single-port-read memory walked one entry at a time by the sequencer, so
// an item's run grows with the entries searched, with the entries moved on
// an insert or drop, and with its results, each of which can wait on a
// stall at the output side. Long items include an insert into a full
// table (two searches, an eviction, the slot search and the shift) and a
// link-down that empties a full table. s_tready is high only between
// items. Configuration writes take effect at once and should be made while
// no item is in progress.
module arp_cache_engine import arp_pkg::*; #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [47:0]  cfg_wdata,
  // Input items
  input  logic         s_tvalid,
  output logic         s_tready,
  // now_seconds, pkt_length, pkt_protocol, pkt_hw_len, pkt_proto_len, pkt_op,
  // sender_mac, sender_ip, target_mac, target_ip, query_ip, zero pad
  input  logic [287:0] s_tdata,
  // action
  input  logic [2:0]   s_tuser,
  // Results
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_mac, result_ip
  output logic [79:0]  m_tdata,
  // result_kind
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  cmd_t cmd;
  sts_t sts;

  arp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arp_datapath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the ARP cache engine: directed table, then random traffic.
module tb;
  import arp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int CYC_LIMIT  = 600000;
  localparam int DRAIN_CYC  = 200;
  localparam int POOL_SIZE  = 24;
  localparam int NO_CHECK   = -1;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] now;
    logic [10:0] len;
    logic [15:0] proto;
    logic [7:0]  hw_len;
    logic [7:0]  pr_len;
    logic [15:0] op;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [47:0] tmac;
    logic [31:0] tip;
    logic [31:0] qip;
    int          first_kind;  // typed expectation of the first result, or NO_CHECK
  } arp_item_t;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        last;
  } arp_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_addr = REG_OWN_MAC;
  logic [47:0]   cfg_wdata = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [287:0]  s_tdata = '0;
  logic [2:0]    s_tuser = ACT_PKT;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [79:0]   m_tdata;
  logic [2:0]    m_tuser;
  logic          m_tlast;

  arp_cache_engine #(.CACHE_ENTRIES(DEPTH)) dut (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always #10 clk = ~clk;

  // Shadow cache and registers
  logic [31:0] sh_ip [DEPTH];
  logic [47:0] sh_mac [DEPTH];
  logic [31:0] sh_exp [DEPTH];
  int          sh_count = 0;
  logic [47:0] my_mac = '0;
  logic [31:0] my_ip = '0;
  logic [15:0] learn_to = RES_TO_RESET;
  logic [15:0] pend_to = INC_TO_RESET;

  arp_result_t result_q [$];
  int          first_kind_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          at_first = 1'b1;
  logic [31:0] ip_pool [POOL_SIZE];
  logic [31:0] clock_s = '0;
  arp_item_t   dir_tab [$];

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void push_result(logic [2:0] kind, logic [47:0] mac, logic [31:0] ip,
                                      logic last);
    arp_result_t r;
    r.kind = kind; r.mac = mac; r.ip = ip; r.last = last;
    result_q.push_back(r);
  endfunction

  function automatic logic [31:0] expiry_sum(logic [31:0] now, logic [15:0] to);
    logic [32:0] s;
    s = {1'b0, now} + {17'd0, to};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic int tbl_find(logic [31:0] ip);
    for (int i = 0; i < sh_count; i++)
      if (sh_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic void tbl_drop(int idx);
    logic        unres;
    logic [31:0] ip;
    unres = (sh_mac[idx] == ZERO_MAC);
    ip = sh_ip[idx];
    for (int i = idx; i + 1 < sh_count; i++) begin
      sh_ip[i] = sh_ip[i+1]; sh_mac[i] = sh_mac[i+1]; sh_exp[i] = sh_exp[i+1];
    end
    sh_count--;
    if (unres) push_result(KIND_NOTRES, ZERO_MAC, ip, 1'b0);
  endfunction

  function automatic void tbl_insert(logic [31:0] ip, logic [47:0] mac, logic [31:0] now,
                                     logic [15:0] to);
    int          pos;
    logic [31:0] ex;
    ex = '0;
    if (tbl_find(ip) >= 0) return;
    if (sh_count >= DEPTH) begin
      if (sh_exp[0] == 0) return;
      tbl_drop(0);
    end
    pos = sh_count;
    if (to != 0) begin
      ex = expiry_sum(now, to);
      for (int i = 0; i < sh_count; i++)
        if (sh_exp[i] > ex || sh_exp[i] == 0) begin
          pos = i;
          break;
        end
    end
    for (int i = sh_count; i > pos; i--) begin
      sh_ip[i] = sh_ip[i-1]; sh_mac[i] = sh_mac[i-1]; sh_exp[i] = sh_exp[i-1];
    end
    sh_ip[pos] = ip; sh_mac[pos] = mac; sh_exp[pos] = ex;
    sh_count++;
  endfunction

  // Expected results of one accepted item
  function automatic void predict_arp_item(arp_item_t it);
    int idx;
    case (it.act)
      ACT_PKT: begin
        if (it.len >= ARP_MIN_LEN && it.proto == ETH_P_IP && it.hw_len == ARP_HW_LEN &&
            it.pr_len == ARP_PR_LEN) begin
          if (it.op == OP_REQ) begin
            if (it.tip == my_ip) begin
              push_result(KIND_REPLY, it.smac, it.sip, 1'b0);
              tbl_insert(it.sip, it.smac, it.now, learn_to);
            end
            if (it.tip == it.sip && it.tmac == ZERO_MAC)
              tbl_insert(it.sip, it.smac, it.now, learn_to);
          end else if (it.op == OP_REP && it.tmac == my_mac) begin
            idx = tbl_find(it.sip);
            if (idx >= 0) begin
              sh_mac[idx] = it.smac;
              sh_exp[idx] = expiry_sum(it.now, learn_to);
            end
            push_result(KIND_RESOLVED, it.smac, it.sip, 1'b0);
          end
        end
      end
      ACT_RES: begin
        idx = tbl_find(it.qip);
        if (idx >= 0) push_result(KIND_HIT, sh_mac[idx], it.qip, 1'b0);
        else begin
          tbl_insert(it.qip, ZERO_MAC, it.now, pend_to);
          push_result(KIND_REQ, BCAST_MAC, it.qip, 1'b0);
          push_result(KIND_MISS, ZERO_MAC, it.qip, 1'b0);
        end
      end
      ACT_TICK:
        while (sh_count > 0 && sh_exp[0] != 0 && sh_exp[0] <= it.now) tbl_drop(0);
      ACT_UP:
        if (my_ip != 0) push_result(KIND_REQ, BCAST_MAC, my_ip, 1'b0);
      ACT_DOWN:
        while (sh_count > 0 && sh_exp[0] != 0) tbl_drop(0);
      ACT_RM: begin
        idx = tbl_find(it.qip);
        if (idx >= 0) tbl_drop(idx);
      end
      default: ;
    endcase
    push_result(KIND_DONE, ZERO_MAC, '0, 1'b1);
  endfunction

  function automatic logic [287:0] pack_item(arp_item_t it);
    return {5'd0, it.qip, it.tip, it.tmac, it.sip, it.smac, it.op, it.pr_len, it.hw_len,
            it.proto, it.len, it.now};
  endfunction

  function automatic arp_item_t mk(logic [2:0] act, logic [31:0] now, logic [10:0] len,
                                   logic [15:0] proto, logic [7:0] hw, logic [7:0] pl,
                                   logic [15:0] op, logic [47:0] smac, logic [31:0] sip,
                                   logic [47:0] tmac, logic [31:0] tip, logic [31:0] qip,
                                   int fk);
    arp_item_t it;
    it.act = act; it.now = now; it.len = len; it.proto = proto; it.hw_len = hw;
    it.pr_len = pl; it.op = op; it.smac = smac; it.sip = sip; it.tmac = tmac;
    it.tip = tip; it.qip = qip; it.first_kind = fk;
    return it;
  endfunction

  // Register write; the block is idle here
  task automatic write_reg(logic [1:0] addr, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= addr; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_OWN_MAC: my_mac = val;
      REG_OWN_IP:  my_ip = val[31:0];
      REG_RES_TO:  learn_to = val[15:0];
      default:     pend_to = val[15:0];
    endcase
  endtask

  // Offer one item, optionally after idle cycles, and predict it on transfer
  task automatic send_item(arp_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_item(it);
    s_tuser <= it.act;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    predict_arp_item(it);
    first_kind_q.push_back(it.first_kind);
  endtask

  task automatic wait_idle();
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(0, 9) < 8) ? ip_pool[$urandom_range(0, POOL_SIZE-1)] : $urandom;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Random item: mostly well-formed packets and commands on pooled addresses
  function automatic arp_item_t rand_item();
    arp_item_t it;
    int        pick;
    int        brk;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_s = clock_s + $urandom_range(200, 70000);
    else clock_s = clock_s + $urandom_range(0, 4);
    if ($urandom_range(0, 49) == 0) clock_s = 32'hffff_ffff - $urandom_range(0, 5);
    it = mk(ACT_PKT, clock_s, 11'($urandom_range(8, 2047)), ETH_P_IP, ARP_HW_LEN,
            ARP_PR_LEN, $urandom_range(0, 1) ? OP_REQ : OP_REP, rand_mac(), pick_ip(),
            rand_mac(), pick_ip(), pick_ip(), NO_CHECK);
    if (pick < 45) begin
      if (it.op == OP_REQ) begin
        case ($urandom_range(0, 2))
          0: it.tip = my_ip;
          1: begin it.tip = it.sip; it.tmac = ZERO_MAC; end
          default: ;
        endcase
      end else if ($urandom_range(0, 3) != 0) it.tmac = my_mac;
    end else if (pick < 50) begin
      brk = $urandom_range(0, 4);
      case (brk)
        0: it.len = 11'($urandom_range(0, 7));
        1: it.proto = 16'($urandom);
        2: it.hw_len = 8'($urandom);
        3: it.pr_len = 8'($urandom);
        default: it.op = 16'($urandom);
      endcase
      if (it.op == OP_REQ) it.tip = my_ip;
    end else if (pick < 70) it.act = ACT_RES;
    else if (pick < 80) it.act = ACT_TICK;
    else if (pick < 85) it.act = ACT_UP;
    else if (pick < 88) it.act = ACT_DOWN;
    else if (pick < 95) it.act = ACT_RM;
    else it.act = 3'($urandom_range(6, 7));
    return it;
  endfunction

  // Result checker
  always @(posedge clk) begin
    arp_result_t e;
    int          fk;
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) report_mismatch("unexpected result", m_tuser, 0);
      else begin
        e = result_q.pop_front();
        if (m_tuser !== e.kind) report_mismatch("result_kind", m_tuser, e.kind);
        if (m_tdata[47:0] !== e.mac) report_mismatch("result_mac", m_tdata[47:0], e.mac);
        if (m_tdata[79:48] !== e.ip) report_mismatch("result_ip", m_tdata[79:48], e.ip);
        if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
      end
      if (at_first && first_kind_q.size() != 0) begin
        fk = first_kind_q.pop_front();
        if (fk != NO_CHECK && m_tuser !== 3'(fk)) report_mismatch("first kind", m_tuser, fk);
      end
      at_first = (m_tlast === 1'b1);
    end
  end

  // Receiver stalls
  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("arp_cache_engine regression: fail");
      $finish;
    end
  end

  localparam logic [31:0] IP_A = 32'h0a00_0001;
  localparam logic [31:0] IP_B = 32'hc0a8_0102;
  localparam logic [31:0] IP_C = 32'hac10_0203;
  localparam logic [31:0] IP_D = 32'h0a00_00fe;
  localparam logic [47:0] MAC_MAX = 48'hffff_ffff_ffff;

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
    ip_pool[0] = 32'h0; ip_pool[1] = 32'hffff_ffff;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at reset configuration: own MAC and own IP both zero
    dir_tab.push_back(mk(ACT_UP, 0, 8, ETH_P_IP, 6, 4, OP_REQ, 0, 0, 0, 0, 0, KIND_DONE));
    dir_tab.push_back(mk(ACT_PKT, 1, 7, ETH_P_IP, 6, 4, OP_REQ, 1, 0, 0, 0, 0, KIND_DONE));
    dir_tab.push_back(mk(ACT_PKT, 1, 8, 16'h86dd, 6, 4, OP_REQ, 1, 0, 0, 0, 0, KIND_DONE));
    dir_tab.push_back(mk(ACT_PKT, 1, 8, ETH_P_IP, 8'hff, 4, OP_REQ, 1, 0, 0, 0, 0, KIND_DONE));
    dir_tab.push_back(mk(ACT_PKT, 1, 8, ETH_P_IP, 6, 8'hff, OP_REQ, 1, 0, 0, 0, 0, KIND_DONE));
    dir_tab.push_back(mk(ACT_PKT, 1, 2047, ETH_P_IP, 6, 4, 16'hffff, 1, 0, 0, 0, 0,
                         KIND_DONE));
    dir_tab.push_back(mk(ACT_PKT, 2, 2047, ETH_P_IP, 6, 4, OP_REQ, MAC_MAX, IP_A, MAC_MAX, 0,
                         0, KIND_REPLY));
    dir_tab.push_back(mk(ACT_RES, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, IP_A, KIND_HIT));
    dir_tab.push_back(mk(ACT_RES, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, IP_B, KIND_REQ));
    dir_tab.push_back(mk(ACT_PKT, 4, 28, ETH_P_IP, 6, 4, OP_REP, 48'h0200_0000_0001, IP_B, 0,
                         0, 0, KIND_RESOLVED));
    dir_tab.push_back(mk(ACT_PKT, 4, 28, ETH_P_IP, 6, 4, OP_REQ, 48'h0200_0000_0002, IP_C, 0,
                         IP_C, 0, KIND_DONE));
    dir_tab.push_back(mk(ACT_PKT, 4, 28, ETH_P_IP, 6, 4, OP_REP, 48'h0200_0000_0003, IP_D, 1,
                         0, 0, KIND_DONE));
    dir_tab.push_back(mk(ACT_RES, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, IP_D, KIND_REQ));
    dir_tab.push_back(mk(ACT_TICK, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_NOTRES));
    dir_tab.push_back(mk(ACT_RM, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0, IP_C, KIND_DONE));
    dir_tab.push_back(mk(ACT_RM, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0, IP_D, KIND_DONE));
    dir_tab.push_back(mk(3'd6, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_DONE));
    dir_tab.push_back(mk(3'd7, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_DONE));
    dir_tab.push_back(mk(ACT_DOWN, 21, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_DONE));
    // Expiry saturates at the top of the clock, then a tick at the top drops it
    dir_tab.push_back(mk(ACT_RES, 32'hffff_fffe, 0, 0, 0, 0, 0, 0, 0, 0, 0, IP_D, KIND_REQ));
    dir_tab.push_back(mk(ACT_TICK, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_NOTRES));
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    s_tvalid <= 1'b0;
    wait_idle();

    // Random phases, each under its own configuration and idling mode
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_OWN_MAC, rand_mac());
          write_reg(REG_OWN_IP, ip_pool[2]);
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          write_reg(REG_OWN_MAC, MAC_MAX);
          write_reg(REG_OWN_IP, 32'hffff_ffff);
          write_reg(REG_RES_TO, 16'hffff);
          write_reg(REG_INC_TO, 16'd1);
          idle_pct = 55; stall_pct = 0;
        end
        2: begin
          write_reg(REG_OWN_MAC, ZERO_MAC);
          write_reg(REG_OWN_IP, 32'h0);
          write_reg(REG_RES_TO, 16'd1);
          write_reg(REG_INC_TO, 16'hffff);
          idle_pct = 0; stall_pct = 55;
        end
        default: begin
          // Zero timeouts store static entries, so the table can fill with them
          write_reg(REG_OWN_MAC, rand_mac());
          write_reg(REG_OWN_IP, ip_pool[3]);
          write_reg(REG_RES_TO, 16'd0);
          write_reg(REG_INC_TO, 16'd0);
          idle_pct = 17; stall_pct = 17;
        end
      endcase
      for (int n = 0; n < 25; n++) send_item(rand_item());
      s_tvalid <= 1'b0;
      wait_idle();
    end

    if (errors == 0) begin
      $display("arp_cache_engine regression: pass");
    end else begin
      $display("arp_cache_engine regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/arp_pkg.sv
design/arp_datapath.sv
design/arp_controller.sv
design/arp_cache_engine.sv
verif/tb.sv
